// File: rtl/assert_macros.svh
// Concurrent assertion macros used by the top-level RTL module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/pmss_pkg.sv
// Types, constants and helper functions of the pixel mask stage selector
package pmss_pkg;

  localparam int COLUMNS = 400;
  localparam int ROWS    = 192;

  localparam int COL_W = 9;
  localparam int ROW_W = 8;
  localparam int SER_W = 11;
  localparam int REM_W = 12;
  localparam int CNT_W = 12;
  localparam int STG_W = 11;
  localparam int NWR   = 9;
  localparam int NNB   = NWR - 1;
  localparam int IDX_W = $clog2(NWR);
  localparam int NB_TABLES   = 5;
  localparam int TBL_W       = $clog2(NB_TABLES);
  localparam int NB_PATTERNS = 12;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0] COL_PREV = COL_W'(COLUMNS - 2);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  localparam logic [COL_W-1:0] SQ_LIN_LO = 9'd128;
  localparam logic [COL_W-1:0] SQ_LIN_HI = 9'd263;
  localparam logic [COL_W-1:0] SQ_SYNC   = 9'd127;
  localparam logic [COL_W-1:0] SQ_DIFF   = 9'd264;
  localparam logic [COL_W-1:0] RC_LIN_LO = 9'd129;
  localparam logic [COL_W-1:0] RC_LIN_HI = 9'd262;
  localparam logic [COL_W-1:0] RC_SYNC   = 9'd126;
  localparam logic [COL_W-1:0] RC_DIFF   = 9'd265;

  localparam logic [1:0] SCAN_STD    = 2'd0;
  localparam logic [1:0] SCAN_XT_NB  = 2'd1;
  localparam logic [1:0] SCAN_XT_CTR = 2'd2;

  localparam logic [1:0] SENSOR_SQ = 2'd0;
  localparam logic [1:0] SENSOR_UD = 2'd1;
  localparam logic [1:0] SENSOR_DU = 2'd2;

  localparam logic [2:0] EDGE_ALL    = 3'd0;
  localparam logic [2:0] EDGE_NONE   = 3'd1;
  localparam logic [2:0] EDGE_SYNC   = 3'd2;
  localparam logic [2:0] EDGE_LIN    = 3'd3;
  localparam logic [2:0] EDGE_DIFF   = 3'd4;
  localparam logic [2:0] EDGE_CORNER = 3'd5;

  localparam logic [2:0] REG_SCAN_MODE    = 3'd0;
  localparam logic [2:0] REG_NB_PATTERN   = 3'd1;
  localparam logic [2:0] REG_SENSOR_TYPE  = 3'd2;
  localparam logic [2:0] REG_EDGE_POLICY  = 3'd3;
  localparam logic [2:0] REG_STAGE_COUNT  = 3'd4;
  localparam logic [2:0] REG_MASK_STAGE   = 3'd5;

  localparam logic [TBL_W-1:0] TBL_SQ = 3'd0;
  localparam logic [TBL_W-1:0] TBL_UD = 3'd1;
  localparam logic [TBL_W-1:0] TBL_DU = 3'd3;

  typedef logic signed [2:0] pmss_off_t;

  localparam pmss_off_t NB_DC [NB_TABLES][NNB] = '{
    '{ 3'sd0,  3'sd1,  3'sd1,  3'sd1,  3'sd0, -3'sd1, -3'sd1, -3'sd1},
    '{ 3'sd1,  3'sd3,  3'sd2,  3'sd3,  3'sd1, -3'sd1, -3'sd2, -3'sd1},
    '{-3'sd1,  3'sd1,  3'sd2,  3'sd1, -3'sd1, -3'sd3, -3'sd2, -3'sd3},
    '{ 3'sd1,  3'sd3,  3'sd2,  3'sd3,  3'sd1, -3'sd1, -3'sd2, -3'sd1},
    '{-3'sd1,  3'sd1,  3'sd2,  3'sd1, -3'sd1, -3'sd3, -3'sd2, -3'sd3}
  };

  localparam pmss_off_t NB_DR [NB_TABLES][NNB] = '{
    '{ 3'sd1,  3'sd1,  3'sd0, -3'sd1, -3'sd1, -3'sd1,  3'sd0,  3'sd1},
    '{ 3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd1, -3'sd1,  3'sd0,  3'sd0},
    '{ 3'sd1,  3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd1},
    '{ 3'sd1,  3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd1},
    '{ 3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd1, -3'sd1,  3'sd0,  3'sd0}
  };

  localparam logic [NNB-1:0] PATTERN_BITS [NB_PATTERNS] = '{
    8'hFF, 8'h55, 8'h11, 8'h44, 8'h10, 8'h01,
    8'h04, 8'h40, 8'h08, 8'h20, 8'h02, 8'h80
  };

  typedef struct packed {
    logic [NWR-1:0]            mask;
    logic [NWR-1:0][COL_W-1:0] col;
    logic [NWR-1:0][ROW_W-1:0] row;
    logic                      c_en;
    logic                      c_inj;
    logic                      n_en;
    logic                      n_inj;
  } pmss_list_t;

  function automatic logic pmss_excluded(input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] row,
                                         input logic [1:0] sensor,
                                         input logic [2:0] policy);
    logic ex;
    ex = 1'b0;
    if (policy == EDGE_CORNER) begin
      ex = !(col == '0 && row == '0);
    end else if (policy == EDGE_ALL) begin
      ex = 1'b0;
    end else if (sensor == SENSOR_SQ) begin
      ex = (col == '0) || (col == COL_LAST) || (row == '0) || (row == ROW_LAST) ||
           (policy == EDGE_LIN && (col <= SQ_LIN_LO || col >= SQ_LIN_HI)) ||
           (policy == EDGE_SYNC && col >= SQ_SYNC) ||
           (policy == EDGE_DIFF && col <= SQ_DIFF);
    end else begin
      ex = (col == '0) || (col == COL_W'(1)) || (col == COL_LAST) || (col == COL_PREV) ||
           (sensor == SENSOR_UD &&
            ((!col[0] && row == '0) || (col[0] && row == ROW_LAST))) ||
           (sensor == SENSOR_DU &&
            ((col[0] && row == '0) || (!col[0] && row == ROW_LAST))) ||
           (policy == EDGE_LIN && (col <= RC_LIN_LO || col >= RC_LIN_HI)) ||
           (policy == EDGE_SYNC && col >= RC_SYNC) ||
           (policy == EDGE_DIFF && col <= RC_DIFF);
    end
    return ex;
  endfunction

  function automatic logic [REM_W-1:0] pmss_rem_step(input logic [REM_W-1:0] r,
                                                     input logic b,
                                                     input logic [REM_W-1:0] d);
    logic [REM_W-1:0] t;
    t = {r[REM_W-2:0], b};
    return (t >= d) ? t - d : t;
  endfunction

endpackage

// File: rtl/pixel_mask_stage_selector.sv
// Top level of the pixel mask stage selector: config, selection pipeline, write output
//
// Usage
//   Input: drive start with in_func, in_pixel_col, in_pixel_row and in_current_inject;
//   the word is taken at a clock edge where start is high and busy is low.
//   Output: each pixel write is on out_col, out_row, out_pixel_enable and
//   out_inject_enable for one cycle, marked by out_valid; out_last flags the
//   final write of an input word. The receiver cannot stall the block.
//   Config: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high. Write only while the block is idle.
// Pipeline and throughput
//   After the entry register, three stages finish the serial-number remainder,
//   one builds the write list, one loads the serialiser and one drives the ports.
//   A word producing n writes (1 to 9) holds the output serialiser until its
//   last write is sent; words producing none or one write flow at one per cycle
//   while no word with more writes holds the serialiser. busy rises while the
//   serialiser is full and the pipeline behind it has filled up.
// Reset
//   rst_n low clears the stage valid flags and the serialiser and loads the register defaults.
module pixel_mask_stage_selector import pmss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [COL_W-1:0]  in_pixel_col,
  input  logic [ROW_W-1:0]  in_pixel_row,
  input  logic              in_current_inject,
  output logic              out_valid,
  output logic [COL_W-1:0]  out_col,
  output logic [ROW_W-1:0]  out_row,
  output logic              out_pixel_enable,
  output logic              out_inject_enable,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_data
);

  localparam int DIV_A = 4;
  localparam int DIV_B = 8;

  logic [1:0]       scan_mode_r;
  logic [3:0]       nb_pattern_r;
  logic [1:0]       sensor_type_r;
  logic [2:0]       edge_policy_r;
  logic [CNT_W-1:0] stage_count_r;
  logic [STG_W-1:0] mask_stage_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic em_ready;

  logic             s1_func_r, s1_inj_r, s1_ok_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [SER_W-1:0] s1_ser_r;
  logic [2:0]       ser_mid;
  logic             in_range;

  logic             s2_func_r, s2_inj_r, s2_ok_r;
  logic [COL_W-1:0] s2_col_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [SER_W-1:0] s2_ser_r;
  logic [REM_W-1:0] s2_rem_r, s2_rem_nxt;

  logic             s3_func_r, s3_inj_r, s3_ok_r;
  logic [COL_W-1:0] s3_col_r;
  logic [ROW_W-1:0] s3_row_r;
  logic [SER_W-1:0] s3_ser_r;
  logic [REM_W-1:0] s3_rem_r, s3_rem_nxt;

  logic             s4_func_r, s4_inj_r, s4_sel_r, s4_sel_nxt;
  logic [COL_W-1:0] s4_col_r;
  logic [ROW_W-1:0] s4_row_r;
  logic [REM_W-1:0] rem_fin;

  pmss_list_t       s5_list_r, s5_list_nxt;

  logic [TBL_W-1:0]          tbl;
  logic                      tbl_ok;
  logic [NNB-1:0]            pat;
  logic signed [COL_W+1:0]   nc;
  logic signed [ROW_W+1:0]   nr;
  logic                      inb;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r   <= SCAN_STD;
      nb_pattern_r  <= 4'd1;
      sensor_type_r <= SENSOR_SQ;
      edge_policy_r <= EDGE_ALL;
      stage_count_r <= CNT_W'(32);
      mask_stage_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCAN_MODE:   scan_mode_r   <= cfg_data[1:0];
        REG_NB_PATTERN:  nb_pattern_r  <= cfg_data[3:0];
        REG_SENSOR_TYPE: sensor_type_r <= cfg_data[1:0];
        REG_EDGE_POLICY: edge_policy_r <= cfg_data[2:0];
        REG_STAGE_COUNT: stage_count_r <= cfg_data;
        REG_MASK_STAGE:  mask_stage_r  <= cfg_data[STG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign rdy5 = !v5_r || em_ready || (s5_list_r.mask == '0);
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign busy = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= start;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: range, edge exclusion, serial number
  assign ser_mid  = in_pixel_col[2:0] + in_pixel_row[5:3];
  assign in_range = (in_pixel_col <= COL_LAST) && (in_pixel_row <= ROW_LAST);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_func_r <= in_func;
      s1_inj_r  <= in_current_inject && in_range;
      s1_col_r  <= in_pixel_col;
      s1_row_r  <= in_pixel_row;
      s1_ok_r   <= in_range &&
                   !pmss_excluded(in_pixel_col, in_pixel_row, sensor_type_r, edge_policy_r);
      s1_ser_r  <= {in_pixel_row[ROW_W-1:3], ser_mid, in_pixel_row[2:0]};
    end
  end

  // stages 2 to 4: remainder of serial by stage count, bits taken four, four and three per stage
  always_comb begin
    s2_rem_nxt = '0;
    for (int i = 0; i < DIV_A; i++) begin
      s2_rem_nxt = pmss_rem_step(s2_rem_nxt, s1_ser_r[SER_W-1-i], stage_count_r);
    end
    s3_rem_nxt = s2_rem_r;
    for (int i = DIV_A; i < DIV_B; i++) begin
      s3_rem_nxt = pmss_rem_step(s3_rem_nxt, s2_ser_r[SER_W-1-i], stage_count_r);
    end
    rem_fin = s3_rem_r;
    for (int i = DIV_B; i < SER_W; i++) begin
      rem_fin = pmss_rem_step(rem_fin, s3_ser_r[SER_W-1-i], stage_count_r);
    end
    s4_sel_nxt = s3_ok_r && (stage_count_r != '0) && (rem_fin == {1'b0, mask_stage_r});
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_func_r <= s1_func_r;
      s2_inj_r  <= s1_inj_r;
      s2_ok_r   <= s1_ok_r;
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_ser_r  <= s1_ser_r;
      s2_rem_r  <= s2_rem_nxt;
    end
    if (rdy3) begin
      s3_func_r <= s2_func_r;
      s3_inj_r  <= s2_inj_r;
      s3_ok_r   <= s2_ok_r;
      s3_col_r  <= s2_col_r;
      s3_row_r  <= s2_row_r;
      s3_ser_r  <= s2_ser_r;
      s3_rem_r  <= s3_rem_nxt;
    end
    if (rdy4) begin
      s4_func_r <= s3_func_r;
      s4_inj_r  <= s3_inj_r;
      s4_col_r  <= s3_col_r;
      s4_row_r  <= s3_row_r;
      s4_sel_r  <= s4_sel_nxt;
    end
  end

  // stage 5: build the write list, centre first then neighbours in table order
  always_comb begin
    tbl_ok = 1'b1;
    case (sensor_type_r)
      SENSOR_SQ: tbl = TBL_SQ;
      SENSOR_UD: tbl = TBL_UD + TBL_W'(s4_col_r[0]);
      SENSOR_DU: tbl = TBL_DU + TBL_W'(s4_col_r[0]);
      default: begin
        tbl    = TBL_SQ;
        tbl_ok = 1'b0;
      end
    endcase
    pat = (nb_pattern_r < 4'(NB_PATTERNS)) ? PATTERN_BITS[nb_pattern_r] : '0;

    s5_list_nxt        = '0;
    s5_list_nxt.col[0] = s4_col_r;
    s5_list_nxt.row[0] = s4_row_r;
    nc  = '0;
    nr  = '0;
    inb = 1'b0;
    for (int i = 0; i < NNB; i++) begin
      nc  = $signed({2'b00, s4_col_r}) + (COL_W+2)'(NB_DC[tbl][i]);
      nr  = $signed({2'b00, s4_row_r}) + (ROW_W+2)'(NB_DR[tbl][i]);
      inb = (nc >= 0) && (nc <= $signed((COL_W+2)'(COLUMNS - 1))) &&
            (nr >= 0) && (nr <= $signed((ROW_W+2)'(ROWS - 1)));
      s5_list_nxt.col[i+1] = nc[COL_W-1:0];
      s5_list_nxt.row[i+1] = nr[ROW_W-1:0];
      s5_list_nxt.mask[i+1] = (scan_mode_r == SCAN_XT_NB || scan_mode_r == SCAN_XT_CTR) &&
                              s4_sel_r && tbl_ok && pat[i] && inb;
    end

    case (scan_mode_r)
      SCAN_STD: begin
        s5_list_nxt.mask[0] = !s4_func_r && (s4_sel_r || s4_inj_r);
        s5_list_nxt.c_en    = s4_sel_r;
        s5_list_nxt.c_inj   = s4_sel_r;
      end
      SCAN_XT_NB: begin
        s5_list_nxt.mask[0] = s4_sel_r;
        s5_list_nxt.c_en    = !s4_func_r;
        s5_list_nxt.n_inj   = !s4_func_r;
      end
      SCAN_XT_CTR: begin
        s5_list_nxt.mask[0] = s4_sel_r;
        s5_list_nxt.c_inj   = !s4_func_r;
        s5_list_nxt.n_en    = !s4_func_r;
      end
      default: s5_list_nxt.mask = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) s5_list_r <= s5_list_nxt;
  end

  pmss_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (v5_r),
    .in_list           (s5_list_r),
    .ready             (em_ready),
    .out_valid         (out_valid),
    .out_col           (out_col),
    .out_row           (out_row),
    .out_pixel_enable  (out_pixel_enable),
    .out_inject_enable (out_inject_enable),
    .out_last          (out_last)
  );

`include "assert_macros.svh"

  `ASSERT_IMPL(a_busy_needs_entry, busy, v1_r && v2_r && v3_r && v4_r && v5_r)
  `ASSERT_NEXT(a_burst_continues, out_valid && !out_last, out_valid)
  `ASSERT_NEXT(a_entry_holds, v1_r && busy, v1_r)
  `ASSERT_IMPL(a_last_in_word, out_last, out_valid)

endmodule

// File: rtl/pmss_emit.sv
// Write serialiser: sends one pixel write per cycle from a list of up to nine
module pmss_emit import pmss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pmss_list_t        in_list,
  output logic              ready,
  output logic              out_valid,
  output logic [COL_W-1:0]  out_col,
  output logic [ROW_W-1:0]  out_row,
  output logic              out_pixel_enable,
  output logic              out_inject_enable,
  output logic              out_last
);

  logic [NWR-1:0]            mask_r, mask_nxt, rest;
  logic [NWR-1:0][COL_W-1:0] col_r;
  logic [NWR-1:0][ROW_W-1:0] row_r;
  logic                      c_en_r, c_inj_r, n_en_r, n_inj_r;
  logic [IDX_W-1:0]          idx;
  logic                      load;
  logic                      out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]          out_col_r, out_col_nxt;
  logic [ROW_W-1:0]          out_row_r, out_row_nxt;
  logic                      out_en_r, out_en_nxt, out_inj_r, out_inj_nxt;
  logic                      out_last_r, out_last_nxt;

  assign rest  = mask_r & (mask_r - NWR'(1));
  assign ready = (rest == '0);
  assign load  = in_valid && ready && (in_list.mask != '0);

  always_comb begin
    idx = '0;
    for (int i = NWR - 1; i >= 0; i--) begin
      if (mask_r[i]) idx = IDX_W'(i);
    end
    mask_nxt      = load ? in_list.mask : rest;
    out_valid_nxt = (mask_r != '0);
    out_col_nxt   = col_r[idx];
    out_row_nxt   = row_r[idx];
    out_en_nxt    = (idx == '0) ? c_en_r : n_en_r;
    out_inj_nxt   = (idx == '0) ? c_inj_r : n_inj_r;
    out_last_nxt  = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col_r   <= in_list.col;
      row_r   <= in_list.row;
      c_en_r  <= in_list.c_en;
      c_inj_r <= in_list.c_inj;
      n_en_r  <= in_list.n_en;
      n_inj_r <= in_list.n_inj;
    end
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_en_r   <= out_en_nxt;
    out_inj_r  <= out_inj_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_col           = out_col_r;
  assign out_row           = out_row_r;
  assign out_pixel_enable  = out_en_r;
  assign out_inject_enable = out_inj_r;
  assign out_last          = out_last_r && out_valid_r;

endmodule

// File: test/pixel_mask_stage_selector_tb.sv
// Testbench for the pixel mask stage selector: directed and random words against a predictor
module pixel_mask_stage_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmss_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_PAD       = 12;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 17;
  localparam int REPORT_LIMIT    = 10;

  localparam logic       FUNC_SETUP    = 1'b0;
  localparam logic       FUNC_CLEANUP  = 1'b1;
  localparam logic [1:0] SCAN_UNDEF    = 2'd3;
  localparam logic [1:0] SENSOR_UNDEF  = 2'd3;
  localparam logic [2:0] EDGE_UNDEF    = 3'd6;
  localparam logic [3:0] PATTERN_ALL   = 4'd0;
  localparam logic [3:0] PATTERN_UNDEF = 4'd13;
  localparam logic [3:0] PATTERN_TOP   = 4'd15;

  // neighbour offsets: square, up-down even/odd, down-up even/odd
  localparam int NBR_DC [5][8] = '{
    '{ 0,  1,  1,  1,  0, -1, -1, -1},
    '{ 1,  3,  2,  3,  1, -1, -2, -1},
    '{-1,  1,  2,  1, -1, -3, -2, -3},
    '{ 1,  3,  2,  3,  1, -1, -2, -1},
    '{-1,  1,  2,  1, -1, -3, -2, -3}
  };
  localparam int NBR_DR [5][8] = '{
    '{ 1,  1,  0, -1, -1, -1,  0,  1},
    '{ 0,  0,  0, -1, -1, -1,  0,  0},
    '{ 1,  1,  0,  0,  0,  0,  0,  1},
    '{ 1,  1,  0,  0,  0,  0,  0,  1},
    '{ 0,  0,  0, -1, -1, -1,  0,  0}
  };
  localparam logic [7:0] NBR_USE [12] = '{
    8'hFF, 8'h55, 8'h11, 8'h44, 8'h10, 8'h01,
    8'h04, 8'h40, 8'h08, 8'h20, 8'h02, 8'h80
  };

  localparam int EDGE_COLS [19] = '{0, 1, 2, 3, 125, 126, 127, 128, 129, 130,
                                    262, 263, 264, 265, 266, 396, 397, 398, 399};
  localparam int EDGE_ROWS [6]  = '{0, 1, 2, 189, 190, 191};

  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             en;
    logic             inj;
    logic             last;
  } pix_write_t;

  class mask_write_ledger;
    logic [1:0]       scan_mode;
    logic [3:0]       nbr_pattern;
    logic [1:0]       sensor;
    logic [2:0]       policy;
    logic [CNT_W-1:0] stage_count;
    logic [STG_W-1:0] mask_stage;
    pix_write_t       pending_writes[$];
    int               words_noted;
    int               writes_checked;
    int               mismatches;

    function new();
      scan_mode      = SCAN_STD;
      nbr_pattern    = 4'd1;
      sensor         = SENSOR_SQ;
      policy         = EDGE_ALL;
      stage_count    = 12'd32;
      mask_stage     = '0;
      words_noted    = 0;
      writes_checked = 0;
      mismatches     = 0;
    endfunction

    function void queue_write(ref pix_write_t q[$], input pix_write_t w);
      q = {q, w};
    endfunction

    function void set_reg(logic [2:0] idx, logic [CNT_W-1:0] data);
      case (idx)
        REG_SCAN_MODE:   scan_mode   = data[1:0];
        REG_NB_PATTERN:  nbr_pattern = data[3:0];
        REG_SENSOR_TYPE: sensor      = data[1:0];
        REG_EDGE_POLICY: policy      = data[2:0];
        REG_STAGE_COUNT: stage_count = data;
        REG_MASK_STAGE:  mask_stage  = data[STG_W-1:0];
        default: ;
      endcase
    endfunction

    function bit edge_cut(int col, int row);
      if (policy == EDGE_CORNER) return !(col == 0 && row == 0);
      if (policy == EDGE_ALL) return 1'b0;
      if (sensor == SENSOR_SQ)
        return col == 0 || col == COLUMNS - 1 || row == 0 || row == ROWS - 1 ||
               (policy == EDGE_LIN && (col <= 128 || col >= 263)) ||
               (policy == EDGE_SYNC && col >= 127) ||
               (policy == EDGE_DIFF && col <= 264);
      return col <= 1 || col >= COLUMNS - 2 ||
             (sensor == SENSOR_UD &&
              ((col % 2 == 0 && row == 0) || (col % 2 == 1 && row == ROWS - 1))) ||
             (sensor == SENSOR_DU &&
              ((col % 2 == 1 && row == 0) || (col % 2 == 0 && row == ROWS - 1))) ||
             (policy == EDGE_LIN && (col <= 129 || col >= 262)) ||
             (policy == EDGE_SYNC && col >= 126) ||
             (policy == EDGE_DIFF && col <= 265);
    endfunction

    function bit in_stage(int col, int row);
      int band;
      int serial;
      if (edge_cut(col, row) || stage_count == 0) return 1'b0;
      band   = row / 8;
      serial = band * 64 + ((col + band % 8) % 8) * 8 + row % 8;
      return (serial % int'(stage_count)) == int'(mask_stage);
    endfunction

    function void note_word(logic func, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                            logic inj);
      pix_write_t batch[$];
      int         c;
      int         r;
      int         tbl;
      int         nc;
      int         nr;
      bit         sel;
      logic       c_en, c_inj, n_en, n_inj;
      logic [7:0] use_bits;
      words_noted++;
      c = col;
      r = row;
      if (c >= COLUMNS || r >= ROWS) return;
      sel = in_stage(c, r);
      if (scan_mode == SCAN_STD) begin
        if (func == FUNC_SETUP) begin
          if (sel) queue_write(batch, pix_write_t'{col, row, 1'b1, 1'b1, 1'b0});
          else if (inj) queue_write(batch, pix_write_t'{col, row, 1'b0, 1'b0, 1'b0});
        end
      end else if ((scan_mode == SCAN_XT_NB || scan_mode == SCAN_XT_CTR) && sel) begin
        if (func == FUNC_CLEANUP) {c_en, c_inj, n_en, n_inj} = 4'b0000;
        else if (scan_mode == SCAN_XT_NB) {c_en, c_inj, n_en, n_inj} = 4'b1001;
        else {c_en, c_inj, n_en, n_inj} = 4'b0110;
        queue_write(batch, pix_write_t'{col, row, c_en, c_inj, 1'b0});
        use_bits = (nbr_pattern < NB_PATTERNS) ? NBR_USE[nbr_pattern] : 8'h00;
        if (sensor != SENSOR_UNDEF) begin
          if (sensor == SENSOR_SQ) tbl = 0;
          else if (sensor == SENSOR_UD) tbl = 1 + c % 2;
          else tbl = 3 + c % 2;
          for (int i = 0; i < 8; i++) begin
            if (use_bits[i]) begin
              nc = c + NBR_DC[tbl][i];
              nr = r + NBR_DR[tbl][i];
              if (nc >= 0 && nr >= 0 && nc < COLUMNS && nr < ROWS)
                queue_write(batch,
                            pix_write_t'{COL_W'(nc), ROW_W'(nr), n_en, n_inj, 1'b0});
            end
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) queue_write(pending_writes, batch[i]);
    endfunction

    function void check_write(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic en,
                              logic inj, logic last);
      pix_write_t w;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected write: col %0d row %0d en %0b inj %0b last %0b",
                   col, row, en, inj, last);
        return;
      end
      w = pending_writes.pop_front();
      writes_checked++;
      if (col !== w.col || row !== w.row || en !== w.en || inj !== w.inj ||
          last !== w.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("write mismatch: expected col %0d row %0d en %0b inj %0b last %0b",
                   w.col, w.row, w.en, w.inj, w.last);
          $display("                got      col %0d row %0d en %0b inj %0b last %0b",
                   col, row, en, inj, last);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_func;
  logic [COL_W-1:0] in_pixel_col;
  logic [ROW_W-1:0] in_pixel_row;
  logic             in_current_inject;
  logic             out_valid;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             out_pixel_enable;
  logic             out_inject_enable;
  logic             out_last;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [2:0]       cfg_index;
  logic [CNT_W-1:0] cfg_data;

  mask_write_ledger sb;
  bit               gaps_on;
  int               settings_used = 0;
  int               stall_cycles = 0;

  pixel_mask_stage_selector u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_pixel_col      (in_pixel_col),
    .in_pixel_row      (in_pixel_row),
    .in_current_inject (in_current_inject),
    .out_valid         (out_valid),
    .out_col           (out_col),
    .out_row           (out_row),
    .out_pixel_enable  (out_pixel_enable),
    .out_inject_enable (out_inject_enable),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_write(out_col, out_row, out_pixel_enable, out_inject_enable, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("pixel_mask_stage_selector_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(logic func, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                           logic inj);
    start             <= 1'b1;
    in_func           <= func;
    in_pixel_col      <= col;
    in_pixel_row      <= row;
    in_current_inject <= inj;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_word(func, col, row, inj);
    if (gaps_on && $urandom_range(0, 3) == 0) idle($urandom_range(1, 3));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(logic [1:0] mode, logic [3:0] pat, logic [1:0] sens,
                             logic [2:0] pol, logic [CNT_W-1:0] cnt,
                             logic [STG_W-1:0] stg);
    write_reg(REG_SCAN_MODE, CNT_W'(mode));
    write_reg(REG_NB_PATTERN, CNT_W'(pat));
    write_reg(REG_SENSOR_TYPE, CNT_W'(sens));
    write_reg(REG_EDGE_POLICY, CNT_W'(pol));
    write_reg(REG_STAGE_COUNT, cnt);
    write_reg(REG_MASK_STAGE, CNT_W'(stg));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_pixel(output logic [COL_W-1:0] col, output logic [ROW_W-1:0] row);
    case ($urandom_range(0, 9))
      0: begin
        col = COL_W'($urandom);
        row = ROW_W'($urandom);
      end
      1, 2: begin
        col = COL_W'(EDGE_COLS[$urandom_range(0, 18)]);
        row = ROW_W'(EDGE_ROWS[$urandom_range(0, 5)]);
      end
      default: begin
        col = COL_W'($urandom_range(0, COLUMNS - 1));
        row = ROW_W'($urandom_range(0, ROWS - 1));
      end
    endcase
  endtask

  task automatic random_phase(int phase);
    logic [1:0]       mode;
    logic [CNT_W-1:0] cnt;
    logic [STG_W-1:0] stg;
    logic [COL_W-1:0] pc;
    logic [ROW_W-1:0] pr;
    int               k;
    mode = ($urandom_range(0, 7) == 0) ? SCAN_UNDEF : 2'($urandom_range(0, 2));
    case (phase)
      0: begin
        cnt = '0;
        stg = STG_W'($urandom);
      end
      1: begin
        cnt = 12'd4095;
        stg = 11'd2047;
      end
      2: begin
        cnt = 12'd2048;
        stg = STG_W'($urandom_range(0, 7));
      end
      default: begin
        cnt = CNT_W'($urandom_range(1, 6));
        stg = STG_W'($urandom_range(0, cnt - 1));
      end
    endcase
    load_config(mode, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                3'(phase % 8), cnt, stg);
    gaps_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
    k = 0;
    while (k < WORDS_PER_PHASE) begin
      pick_pixel(pc, pr);
      if ((mode == SCAN_XT_NB || mode == SCAN_XT_CTR) && $urandom_range(0, 9) < 6) begin
        send_word(FUNC_SETUP, pc, pr, 1'($urandom_range(0, 1)));
        send_word(FUNC_CLEANUP, pc, pr, 1'($urandom_range(0, 1)));
        k += 2;
      end else begin
        send_word(1'($urandom_range(0, 1)), pc, pr, 1'($urandom_range(0, 1)));
        k++;
      end
    end
    drain();
  endtask

  initial begin
    sb                = new();
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_func           <= 1'b0;
    in_pixel_col      <= '0;
    in_pixel_row      <= '0;
    in_current_inject <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    gaps_on           = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, standard mode
    send_word(FUNC_SETUP, 9'd0, 8'd0, 1'b0);
    send_word(FUNC_CLEANUP, 9'd0, 8'd0, 1'b1);
    send_word(FUNC_SETUP, 9'd399, 8'd191, 1'b1);
    send_word(FUNC_SETUP, 9'd400, 8'd0, 1'b1);
    send_word(FUNC_SETUP, 9'd511, 8'd255, 1'b1);
    send_word(FUNC_SETUP, 9'd5, 8'd3, 1'b0);
    drain();

    // every pixel in stage, full square neighbourhood
    load_config(SCAN_XT_NB, PATTERN_ALL, SENSOR_SQ, EDGE_ALL, 12'd1, 11'd0);
    send_word(FUNC_SETUP, 9'd0, 8'd0, 1'b0);
    send_word(FUNC_SETUP, 9'd200, 8'd100, 1'b0);
    send_word(FUNC_CLEANUP, 9'd200, 8'd100, 1'b1);
    send_word(FUNC_SETUP, 9'd399, 8'd191, 1'b1);
    drain();

    load_config(SCAN_XT_CTR, PATTERN_ALL, SENSOR_UD, EDGE_NONE, 12'd1, 11'd0);
    send_word(FUNC_SETUP, 9'd200, 8'd100, 1'b0);
    send_word(FUNC_SETUP, 9'd201, 8'd100, 1'b0);
    send_word(FUNC_SETUP, 9'd1, 8'd50, 1'b0);
    send_word(FUNC_SETUP, 9'd200, 8'd0, 1'b0);
    send_word(FUNC_SETUP, 9'd201, 8'd0, 1'b0);
    drain();

    // odd columns of the down-up sensor take their own table
    load_config(SCAN_XT_CTR, PATTERN_ALL, SENSOR_DU, EDGE_NONE, 12'd1, 11'd0);
    send_word(FUNC_SETUP, 9'd201, 8'd101, 1'b0);
    send_word(FUNC_SETUP, 9'd200, 8'd101, 1'b0);
    send_word(FUNC_CLEANUP, 9'd201, 8'd101, 1'b0);
    drain();

    load_config(SCAN_UNDEF, PATTERN_TOP, SENSOR_SQ, EDGE_ALL, 12'd1, 11'd0);
    send_word(FUNC_SETUP, 9'd200, 8'd100, 1'b1);
    send_word(FUNC_CLEANUP, 9'd200, 8'd100, 1'b1);
    drain();

    load_config(SCAN_XT_NB, PATTERN_UNDEF, SENSOR_UNDEF, EDGE_UNDEF, 12'd1, 11'd0);
    send_word(FUNC_SETUP, 9'd200, 8'd100, 1'b0);
    send_word(FUNC_SETUP, 9'd1, 8'd100, 1'b0);
    send_word(FUNC_SETUP, 9'd200, 8'd0, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

    $display("run covered %0d pixel words, %0d checked writes, %0d register settings",
             sb.words_noted, sb.writes_checked, settings_used);
    $display("mismatches %0d, writes never seen %0d", sb.mismatches,
             sb.pending_writes.size());
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
      $display("pixel_mask_stage_selector_tb OK");
    end else begin
      $display("pixel_mask_stage_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: pixel_mask_stage_selector.f
+incdir+rtl
rtl/pmss_pkg.sv
rtl/pmss_emit.sv
rtl/pixel_mask_stage_selector.sv
test/pixel_mask_stage_selector_tb.sv
